// ===== hdl/rces_pkg.sv =====
// rces_pkg: widths, codes and item types shared by the range coder
// statistics unit, its divider and its multiply-accumulate unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rces_pkg;

  localparam int unsigned LowW           = 64;
  localparam int unsigned WordW          = 32;
  localparam int unsigned TotalW         = 17;
  localparam int unsigned FreqW          = 16;
  localparam int unsigned TallyW         = 48;
  localparam int unsigned FlushW         = 33;
  localparam int unsigned DivSteps       = LowW;
  localparam int unsigned DivCntW        = $clog2(DivSteps);
  localparam int unsigned ProdW          = WordW + FreqW;
  localparam int unsigned CounterBitsDef = 48;

  localparam logic [TotalW-1:0] ModelTotalRst = 17'h10000;
  localparam logic [WordW-1:0]  WordOnes      = '1;
  localparam logic [FlushW-1:0] FlushBase     = 33'd3;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI
  } mul_op_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic             mode;
    logic [FreqW-1:0] cum_low;
    logic [FreqW-1:0] freq;
  } in_item_t;

  typedef struct packed {
    logic              carry_flag;
    logic              renorm_flag;
    logic              straddle_flag;
    logic [WordW-1:0]  pending_ff;
    logic [WordW-1:0]  cache_word;
    logic [TallyW-1:0] symbol_count;
    logic [TallyW-1:0] carry_hit_count;
    logic [TallyW-1:0] renorm_hit_count;
    logic [TallyW-1:0] straddle_hit_count;
    logic [TallyW-1:0] flushed_ff_count;
    logic [WordW-1:0]  longest_ff_chain;
    logic [FlushW-1:0] flush_word_count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/rces_div.sv =====
// rces_div: radix-2 restoring divider, 64-bit dividend by 17-bit divisor,
// one quotient bit per cycle. Uses rces_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rces_div import rces_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [LowW-1:0]   dividend_i,
  input  wire logic [TotalW-1:0] divisor_i,
  output div_stat_t              stat_o,
  output logic      [LowW-1:0]   quotient_o
);

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [LowW-1:0]    quot_q;
  logic [TotalW-1:0]  rem_q;
  logic [TotalW-1:0]  dsor_q;

  logic [TotalW:0]    shifted;
  logic [TotalW:0]    diff;
  logic               ge;
  logic               last;

  // a zero divisor makes every step succeed, so the quotient is all ones
  assign shifted = {rem_q, quot_q[LowW-1]};
  assign ge      = shifted >= {1'b0, dsor_q};
  assign diff    = shifted - {1'b0, dsor_q};
  assign last    = busy_q && (cnt_q == DivCntW'(DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsor_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[LowW-2:0], ge};
      rem_q  <= ge ? diff[TotalW-1:0] : shifted[TotalW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = last;
  assign quotient_o  = quot_q;

endmodule

`default_nettype wire

// ===== hdl/rces_mul.sv =====
// rces_mul: one 32x16 multiplier with a 64-bit accumulator, used for the
// partial products of a 64x16 product modulo 2^64. Uses rces_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rces_mul import rces_pkg::*; (
  input  wire logic             clk_i,
  input  wire mul_op_e          op_i,
  input  wire logic [WordW-1:0] a_i,
  input  wire logic [FreqW-1:0] b_i,
  output logic      [LowW-1:0]  acc_o
);

  logic [ProdW-1:0] prod;
  logic [LowW-1:0]  acc_q;
  logic [LowW-1:0]  acc_d;

  assign prod = ProdW'(a_i) * ProdW'(b_i);

  // high partial product only keeps its low word once shifted by 32
  always_comb begin
    unique case (op_i)
      MUL_LO:  acc_d = LowW'(prod);
      MUL_HI:  acc_d = acc_q + {prod[WordW-1:0], WordW'(0)};
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== hdl/range_coder_encode_stats_unit.sv =====
// range_coder_encode_stats_unit: top level of the range coder statistics
// unit; sequencer, coder state and tallies. Uses rces_pkg, rces_div, rces_mul.
//
// Usage:
//   cfg_we_i/cfg_wdata_i write model_total (reset 65536); write only while
//   the unit is idle. Items enter on in_valid_i/in_stall_o and are accepted
//   at an edge with valid high and stall low. in_stall_o is high from the
//   accept until the result has been moved into the output register.
//   Each accepted item gives one result item on out_valid_o/out_item_o,
//   taken at an edge where out_stall_i is low.
// Sequence:
//   encode item: after accept, the 64-step divider runs, followed by four
//   partial products on the shared multiplier, the low add and the
//   renormalize step, then the result is registered. A new item is taken
//   only once the result is registered and the unit is idle again.
//   finish item: goes straight to S_DONE, then into the output register.
// Stall: while out_stall_i holds a result, the next finished result waits
//   in the sequencer and the input keeps stalling.
// Reset: clears the coder state (range all ones) and tallies, and sets
//   model_total back to 65536.
`timescale 1ns / 1ps
`default_nettype none

module range_coder_encode_stats_unit import rces_pkg::*; #(
  parameter int unsigned COUNTER_BITS = CounterBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TotalW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_item_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_ADD,
    S_RENORM,
    S_DONE
  } state_e;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  state_e            state_q, state_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [LowW-1:0]   low_q, low_d;
  logic [LowW-1:0]   range_q, range_d;
  logic [LowW-1:0]   step_q, step_d;
  logic [WordW-1:0]  cache_q, cache_d;
  logic [WordW-1:0]  pend_q, pend_d;
  logic [WordW-1:0]  longest_q, longest_d;
  logic [FlushW-1:0] flush_q, flush_d;
  logic [FreqW-1:0]  cum_q, cum_d;
  logic [FreqW-1:0]  freq_q, freq_d;
  cnt_t              sym_q, sym_d;
  cnt_t              carry_cnt_q, carry_cnt_d;
  cnt_t              renorm_cnt_q, renorm_cnt_d;
  cnt_t              strad_cnt_q, strad_cnt_d;
  cnt_t              rel_cnt_q, rel_cnt_d;
  logic              carry_q, carry_d;
  logic              renorm_q, renorm_d;
  logic              strad_q, strad_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic              accept;
  logic              div_start;
  div_stat_t         div_stat;
  logic [LowW-1:0]   quotient;
  mul_op_e           mul_op;
  logic [WordW-1:0]  mul_a;
  logic [FreqW-1:0]  mul_b;
  logic [LowW-1:0]   acc;
  logic [LowW:0]     low_sum;
  logic [WordW-1:0]  pend_inc;
  logic [WordW-1:0]  longest_run;
  logic [COUNTER_BITS:0] rel_sum;
  cnt_t              rel_sat;
  logic              out_load;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign div_start  = accept && (in_item_i.mode == MODE_ENCODE);

  rces_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (range_q),
    .divisor_i  (total_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // t*cum_low, then t*freq, each as low word plus shifted high word
  always_comb begin
    unique case (state_q)
      S_MUL0: begin
        mul_op = MUL_LO;
        mul_a  = quotient[WordW-1:0];
        mul_b  = cum_q;
      end
      S_MUL1: begin
        mul_op = MUL_HI;
        mul_a  = quotient[LowW-1:WordW];
        mul_b  = cum_q;
      end
      S_MUL2: begin
        mul_op = MUL_LO;
        mul_a  = quotient[WordW-1:0];
        mul_b  = freq_q;
      end
      S_MUL3: begin
        mul_op = MUL_HI;
        mul_a  = quotient[LowW-1:WordW];
        mul_b  = freq_q;
      end
      default: begin
        mul_op = MUL_IDLE;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  rces_mul u_mul (
    .clk_i (clk_i),
    .op_i  (mul_op),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .acc_o (acc)
  );

  assign low_sum     = {1'b0, low_q} + {1'b0, step_q};
  assign pend_inc    = (pend_q == WordOnes) ? pend_q : pend_q + 1'b1;
  assign longest_run = (pend_q > longest_q) ? pend_q : longest_q;
  assign rel_sum     = {1'b0, rel_cnt_q} + (COUNTER_BITS + 1)'(pend_q);
  assign rel_sat     = rel_sum[COUNTER_BITS] ? '1 : rel_sum[COUNTER_BITS-1:0];

  always_comb begin
    state_d      = state_q;
    total_d      = cfg_we_i ? cfg_wdata_i : total_q;
    low_d        = low_q;
    range_d      = range_q;
    step_d       = step_q;
    cache_d      = cache_q;
    pend_d       = pend_q;
    longest_d    = longest_q;
    flush_d      = flush_q;
    cum_d        = cum_q;
    freq_d       = freq_q;
    sym_d        = sym_q;
    carry_cnt_d  = carry_cnt_q;
    renorm_cnt_d = renorm_cnt_q;
    strad_cnt_d  = strad_cnt_q;
    rel_cnt_d    = rel_cnt_q;
    carry_d      = carry_q;
    renorm_d     = renorm_q;
    strad_d      = strad_q;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cum_d    = in_item_i.cum_low;
          freq_d   = in_item_i.freq;
          carry_d  = 1'b0;
          renorm_d = 1'b0;
          strad_d  = 1'b0;
          if (in_item_i.mode == MODE_FINISH) begin
            flush_d = FlushBase + FlushW'(pend_q);
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: begin
        step_d  = acc;
        state_d = S_MUL3;
      end
      S_MUL3: state_d = S_ADD;
      S_ADD: begin
        low_d   = low_sum[LowW-1:0];
        range_d = acc;
        sym_d   = sat_inc(sym_q);
        if (low_sum[LowW]) begin
          carry_d     = 1'b1;
          carry_cnt_d = sat_inc(carry_cnt_q);
          cache_d     = cache_q + 1'b1;
          rel_cnt_d   = rel_sat;
          longest_d   = longest_run;
          pend_d      = '0;
        end
        state_d = S_RENORM;
      end
      S_RENORM: begin
        if (range_q[LowW-1:WordW] == '0) begin
          renorm_d     = 1'b1;
          renorm_cnt_d = sat_inc(renorm_cnt_q);
          low_d        = {low_q[WordW-1:0], WordW'(0)};
          range_d      = {range_q[WordW-1:0], WordW'(0)};
          if (low_q[LowW-1:WordW] == WordOnes) begin
            // top word may still take a carry, so it joins the pending run
            strad_d     = 1'b1;
            strad_cnt_d = sat_inc(strad_cnt_q);
            pend_d      = pend_inc;
            longest_d   = (pend_inc > longest_q) ? pend_inc : longest_q;
          end else begin
            rel_cnt_d = rel_sat;
            longest_d = longest_run;
            pend_d    = '0;
            cache_d   = low_q[LowW-1:WordW];
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_item_d.carry_flag         = carry_q;
    out_item_d.renorm_flag        = renorm_q;
    out_item_d.straddle_flag      = strad_q;
    out_item_d.pending_ff         = pend_q;
    out_item_d.cache_word         = cache_q;
    out_item_d.symbol_count       = TallyW'(sym_q);
    out_item_d.carry_hit_count    = TallyW'(carry_cnt_q);
    out_item_d.renorm_hit_count   = TallyW'(renorm_cnt_q);
    out_item_d.straddle_hit_count = TallyW'(strad_cnt_q);
    out_item_d.flushed_ff_count   = TallyW'(rel_cnt_q);
    out_item_d.longest_ff_chain   = longest_q;
    out_item_d.flush_word_count   = flush_q;
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      total_q      <= ModelTotalRst;
      low_q        <= '0;
      range_q      <= '1;
      cache_q      <= '0;
      pend_q       <= '0;
      longest_q    <= '0;
      flush_q      <= '0;
      sym_q        <= '0;
      carry_cnt_q  <= '0;
      renorm_cnt_q <= '0;
      strad_cnt_q  <= '0;
      rel_cnt_q    <= '0;
      carry_q      <= 1'b0;
      renorm_q     <= 1'b0;
      strad_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      low_q        <= low_d;
      range_q      <= range_d;
      cache_q      <= cache_d;
      pend_q       <= pend_d;
      longest_q    <= longest_d;
      flush_q      <= flush_d;
      sym_q        <= sym_d;
      carry_cnt_q  <= carry_cnt_d;
      renorm_cnt_q <= renorm_cnt_d;
      strad_cnt_q  <= strad_cnt_d;
      rel_cnt_q    <= rel_cnt_d;
      carry_q      <= carry_d;
      renorm_q     <= renorm_d;
      strad_q      <= strad_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    cum_q  <= cum_d;
    freq_q <= freq_d;
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_longest_covers_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    longest_q >= pend_q)
    else $error("longest run below pending run");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted item did not start the sequencer");

  a_div_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> div_stat.busy)
    else $error("divider idle while sequencer waits on it");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  a_renorm_shifted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && renorm_q) |-> range_q[WordW-1:0] == '0)
    else $error("renormalized range not shifted by a word");

  a_sym_only_in_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ADD) |=> $stable(sym_q))
    else $error("symbol tally moved outside the add step");
`endif

endmodule

`default_nettype wire
